[rtl/xpr_pkg.sv]
`default_nettype none

package xpr_pkg;

    // Default depth of the queue between the classifier and the expander.
    localparam int QUEUE_DEPTH = 4;

    // Byte codes the rewriter looks for or produces.
    localparam logic [7:0] CH_SLASH  = 8'h2F;  // /
    localparam logic [7:0] CH_SQUOTE = 8'h27;  // '
    localparam logic [7:0] CH_DQUOTE = 8'h22;  // "

    // The expansion of an absolute slash.
    localparam logic [7:0] ABS_SEQ [4] = '{8'h2F, 8'h5F, 8'h72, 8'h2F};

    // Byte counts saturate here.
    localparam logic [2:0] COUNT_SAT = 3'd4;

    typedef enum logic [1:0] {
        Q_NONE   = 2'd0,
        Q_SINGLE = 2'd1,
        Q_DOUBLE = 2'd2
    } quote_t;

    // What a released held slash expands to.
    typedef enum logic [1:0] {
        PRE_NONE,
        PRE_PLAIN,
        PRE_ABS
    } pre_t;

    // What the current byte itself produces.
    typedef enum logic [1:0] {
        BODY_NONE,
        BODY_BYTE,
        BODY_PLAIN,
        BODY_ABS
    } body_t;

    // One queued work item: everything the expander needs for one input byte.
    typedef struct packed {
        pre_t        pre;
        body_t       body;
        logic [7:0]  byte_val;
        logic        last;
    } xpr_desc_t;

endpackage

`default_nettype wire

[rtl/xpr_if.sv]
`default_nettype none

// Input channel: one expression byte per transaction.
interface xpr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// Output channel: one rewritten byte per transaction.
interface xpr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_end;
    logic       text_end;

    modport source (output valid, output out_byte, output run_end, output text_end,
                     input ready);
    modport sink   (input valid, input out_byte, input run_end, input text_end,
                    output ready);
endinterface

`default_nettype wire

[rtl/xpr_front.sv]
`default_nettype none

module xpr_front
    import xpr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    xpr_in_if.sink         expr,
    input  wire logic      push_ready,
    output xpr_desc_t      push_desc,
    output logic           push_valid
);

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
    endfunction

    function automatic logic closes_operand(input logic [7:0] c);
        return is_space(c) || c == 8'h29 || c == 8'h5D || c == 8'h2A ||
               c == CH_SQUOTE || c == CH_DQUOTE;
    endfunction

    function automatic logic is_boundary(input logic [7:0] c);
        return c == 8'h28 || c == 8'h7C || c == 8'h2C || c == 8'h3D || c == 8'h3C ||
               c == 8'h3E || c == 8'h2B || c == 8'h2D || c == 8'h5B || c == 8'h21;
    endfunction

    function automatic logic three_letter_word(input logic [7:0] b2, input logic [7:0] b1,
                                               input logic [7:0] b0);
        return (b2 == 8'h61 && b1 == 8'h6E && b0 == 8'h64) ||
               (b2 == 8'h64 && b1 == 8'h69 && b0 == 8'h76) ||
               (b2 == 8'h6D && b1 == 8'h6F && b0 == 8'h64);
    endfunction

    quote_t      quote_reg, quote_next;
    logic        held_reg, held_next;
    logic        held_abs_reg, held_abs_next;
    logic [23:0] recent_reg, recent_next;
    logic [31:0] window_reg, window_next;
    logic [2:0]  solid_pos_reg, solid_pos_next;
    logic        solid_seen_reg, solid_seen_next;
    logic [2:0]  count_reg, count_next;

    logic        accept;
    logic        absolute;
    logic [7:0]  c;
    logic [7:0]  b0, b1, b2, b3;

    assign c      = expr.in_byte;
    assign b0     = window_reg[7:0];
    assign b1     = window_reg[15:8];
    assign b2     = window_reg[23:16];
    assign b3     = window_reg[31:24];
    assign accept = expr.valid && expr.ready;

    assign expr.ready = push_ready;

    // A slash starts an absolute path after nothing, after a boundary character,
    // or after a word operator that follows the end of an operand.
    always_comb
    begin
        absolute = !solid_seen_reg || is_boundary(b0) ||
                   (solid_pos_reg >= 3'd2 && b1 == 8'h6F && b0 == 8'h72 &&
                    closes_operand(b2)) ||
                   (solid_pos_reg >= 3'd3 && three_letter_word(b2, b1, b0) &&
                    closes_operand(b3));
    end

    always_comb
    begin
        quote_next      = quote_reg;
        held_next       = held_reg;
        held_abs_next   = held_abs_reg;
        window_next     = window_reg;
        solid_pos_next  = solid_pos_reg;
        solid_seen_next = solid_seen_reg;
        recent_next     = {recent_reg[15:0], c};
        count_next      = (count_reg < COUNT_SAT) ? count_reg + 3'd1 : count_reg;

        push_desc.pre      = PRE_NONE;
        push_desc.body     = BODY_BYTE;
        push_desc.byte_val = c;
        push_desc.last     = expr.in_last;

        if (held_reg)
        begin
            push_desc.pre = (c != CH_SLASH && held_abs_reg) ? PRE_ABS : PRE_PLAIN;
            held_next     = 1'b0;
            held_abs_next = 1'b0;
        end

        if (quote_reg != Q_NONE)
        begin
            if ((quote_reg == Q_SINGLE && c == CH_SQUOTE) ||
                (quote_reg == Q_DOUBLE && c == CH_DQUOTE))
            begin
                quote_next = Q_NONE;
            end
        end
        else if (c == CH_SQUOTE)
        begin
            quote_next = Q_SINGLE;
        end
        else if (c == CH_DQUOTE)
        begin
            quote_next = Q_DOUBLE;
        end
        else if (c == CH_SLASH)
        begin
            if (expr.in_last)
            begin
                push_desc.body = absolute ? BODY_ABS : BODY_PLAIN;
            end
            else
            begin
                push_desc.body = BODY_NONE;
                held_next      = 1'b1;
                held_abs_next  = absolute;
            end
        end

        if (!is_space(c))
        begin
            window_next     = {recent_reg, c};
            solid_pos_next  = count_reg;
            solid_seen_next = 1'b1;
        end

        if (expr.in_last)
        begin
            quote_next      = Q_NONE;
            held_next       = 1'b0;
            held_abs_next   = 1'b0;
            recent_next     = '0;
            window_next     = '0;
            solid_pos_next  = '0;
            solid_seen_next = 1'b0;
            count_next      = '0;
        end

        push_valid = accept && !(push_desc.pre == PRE_NONE && push_desc.body == BODY_NONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_reg      <= Q_NONE;
            held_reg       <= 1'b0;
            held_abs_reg   <= 1'b0;
            recent_reg     <= '0;
            window_reg     <= '0;
            solid_pos_reg  <= '0;
            solid_seen_reg <= 1'b0;
            count_reg      <= '0;
        end
        else if (accept)
        begin
            quote_reg      <= quote_next;
            held_reg       <= held_next;
            held_abs_reg   <= held_abs_next;
            recent_reg     <= recent_next;
            window_reg     <= window_next;
            solid_pos_reg  <= solid_pos_next;
            solid_seen_reg <= solid_seen_next;
            count_reg      <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/xpr_queue.sv]
`default_nettype none

module xpr_queue
    import xpr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push_valid,
    input  xpr_desc_t      push_desc,
    output logic           push_ready,
    output logic           head_valid,
    output xpr_desc_t      head_desc,
    input  wire logic      pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    xpr_desc_t        slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_FULL;
    assign head_valid = count_reg != '0;
    assign head_desc  = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

`default_nettype wire

[rtl/xpr_back.sv]
`default_nettype none

module xpr_back
    import xpr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      head_valid,
    input  xpr_desc_t      head_desc,
    output logic           pop,
    xpr_out_if.source      result
);

    logic [2:0] idx_reg, idx_next;
    logic [2:0] pre_len, body_len;
    logic [3:0] total;
    logic [2:0] final_idx;
    logic [1:0] rel;
    logic       in_pre;
    logic       accept;

    always_comb
    begin
        case (head_desc.pre)
            PRE_PLAIN: pre_len = 3'd1;
            PRE_ABS:   pre_len = 3'd4;
            default:   pre_len = 3'd0;
        endcase
        case (head_desc.body)
            BODY_BYTE, BODY_PLAIN: body_len = 3'd1;
            BODY_ABS:              body_len = 3'd4;
            default:               body_len = 3'd0;
        endcase
        total     = {1'b0, pre_len} + {1'b0, body_len};
        final_idx = 3'(total - 4'd1);
        in_pre    = idx_reg < pre_len;
        rel       = 2'(idx_reg - pre_len);

        if (in_pre)
        begin
            result.out_byte = (head_desc.pre == PRE_ABS) ? ABS_SEQ[idx_reg[1:0]] : CH_SLASH;
        end
        else
        begin
            case (head_desc.body)
                BODY_ABS:   result.out_byte = ABS_SEQ[rel];
                BODY_PLAIN: result.out_byte = CH_SLASH;
                default:    result.out_byte = head_desc.byte_val;
            endcase
        end

        result.valid    = head_valid;
        result.run_end  = idx_reg == final_idx;
        result.text_end = result.run_end && head_desc.last;

        accept   = result.valid && result.ready;
        pop      = accept && result.run_end;
        idx_next = idx_reg;
        if (accept)
        begin
            idx_next = result.run_end ? '0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

`default_nettype wire

[rtl/xpath_absolute_path_rewriter.sv]
// The first byte produced by an input transaction is offered in the cycle after it if the
// queue was empty. Throughput: one input transaction per cycle while the queue has room;
// the output side delivers one byte per cycle while the consumer is ready, and an absolute
// slash is four bytes, a plain byte one. The queue depth sets how much input is absorbed.
// Reset: rst_n is asynchronous and active low; it empties the queue and clears all state.
`default_nettype none

// Top level of the XPath absolute-path rewriter.
//
// The design is split into a classifier front end, a small descriptor queue and a
// byte expander back end. The front end takes one expression byte per transaction,
// tracks quoted literals and the recent non-whitespace context, and decides for every
// slash whether it begins an absolute location path. A slash outside a literal is held
// until the following byte arrives, because the first slash of a double slash is never
// rewritten; on the final byte of the expression it is judged at once.
//
// For every input byte that yields output, the front end pushes one descriptor into the
// queue: what the released held slash expands to (nothing, a plain slash, or "/_r/"),
// what the current byte yields, and whether it ends the expression. The back end walks
// each descriptor one output byte per cycle while the consumer is ready, and flags the last
// byte of each descriptor with run_end, and the final byte of the expression with text_end.
//
// Input ready depends only on the queue fill level, so a stalled consumer never reaches
// the input combinationally, and the producer keeps streaming while the back end works.
module xpath_absolute_path_rewriter
    import xpr_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    xpr_in_if.sink         expr,
    xpr_out_if.source      result
);

    xpr_desc_t push_desc;
    logic      push_valid;
    logic      push_ready;
    xpr_desc_t head_desc;
    logic      head_valid;
    logic      pop;

    xpr_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .expr       (expr),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .push_valid (push_valid)
    );

    xpr_queue #(
        .DEPTH (QDEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_desc  (push_desc),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop)
    );

    xpr_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop),
        .result     (result)
    );

endmodule

`default_nettype wire
